// ===== rtl/core/atht_pkg.sv =====
`default_nettype none
package atht_pkg;

  // Table size must be a power of two: the hash and the probe index wrap by masking.
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int LIM_W = CNT_W + 5;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_ENTRIES - 1);
  // 70% fill threshold, compared against (count + 1) * 10.
  localparam logic [LIM_W-1:0] TBL_LIM = LIM_W'(TABLE_ENTRIES * 7);

  localparam logic [63:0] HASH_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] HASH_C2 = 64'hc4ceb9fe1a85ec53;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_OCC   = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  localparam logic [2:0] ST_NEW      = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FAILED   = 3'd4;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_REALLOC = 2'd2;
  localparam logic [1:0] REQ_FAILREP = 2'd3;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_FREE    = 3'd1,
    OP_REALLOC = 3'd2,
    OP_FAIL    = 3'd3,
    OP_IGNORE  = 3'd4
  } op_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] address;
    logic [63:0] old_address;
    logic [47:0] requested_size;
    logic [47:0] actual_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] live_requested_bytes;
    logic [63:0] live_actual_bytes;
    logic [63:0] live_count;
    logic [63:0] peak_requested_bytes;
    logic [63:0] peak_actual_bytes;
    logic [63:0] peak_count;
    logic [63:0] total_count;
    logic [63:0] failed_count;
    logic [63:0] realloc_count;
    logic [63:0] slack_bytes;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] addr;
    logic [63:0] old_addr;
    logic [47:0] req;
    logic [47:0] act;
  } cmd_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [47:0] req;
    logic [47:0] act;
    logic [1:0]  mark;
  } slot_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [47:0] req;
    logic [47:0] act;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/atht_ram.sv =====
`default_nettype none
module atht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/atht_front.sv =====
`default_nettype none
module atht_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire atht_pkg::in_item_t in_data,
  input  wire logic               clr_busy,
  output atht_pkg::cmd_t          head,
  output logic                    head_valid,
  input  wire logic               pop
);

  atht_pkg::cmd_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  atht_pkg::cmd_t cls;

  // classify: zero address and failure reports never touch the table
  always_comb begin
    cls.addr     = in_data.address;
    cls.old_addr = in_data.old_address;
    cls.req      = in_data.requested_size;
    cls.act      = (in_data.actual_size < in_data.requested_size) ?
                   in_data.requested_size : in_data.actual_size;
    case (in_data.req_type)
      atht_pkg::REQ_ALLOC:
        cls.op = (in_data.address == 64'd0) ? atht_pkg::OP_FAIL : atht_pkg::OP_ALLOC;
      atht_pkg::REQ_FREE:
        cls.op = (in_data.address == 64'd0) ? atht_pkg::OP_IGNORE : atht_pkg::OP_FREE;
      atht_pkg::REQ_REALLOC:
        cls.op = (in_data.address == 64'd0) ? atht_pkg::OP_FAIL : atht_pkg::OP_REALLOC;
      default:
        cls.op = atht_pkg::OP_FAIL;
    endcase
  end

  assign in_ready   = (cnt_r != 2'd2) && !clr_busy;
  assign push       = in_valid && in_ready;
  assign head       = q_r[rd_ptr_r];
  assign head_valid = (cnt_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/atht_hash.sv =====
`default_nettype none
module atht_hash (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [63:0]                key,
  output logic                            done,
  output logic [atht_pkg::IDX_W-1:0]      home
);

  // step 1/3: partial products, step 2/4: combine and xor-shift
  logic [2:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] ll_r, ll_nxt;
  logic [31:0] cross_r, cross_nxt;
  logic [atht_pkg::IDX_W-1:0] home_r, home_nxt;
  logic [63:0] c;
  logic [63:0] sh;
  logic [63:0] sum;
  logic [63:0] mix;
  logic [63:0] p_lh;
  logic [63:0] p_hl;

  always_comb begin
    c         = (cnt_r == 3'd1) ? atht_pkg::HASH_C1 : atht_pkg::HASH_C2;
    sh        = key >> 4;
    ll_nxt    = x_r[31:0] * c[31:0];
    p_lh      = x_r[31:0] * c[63:32];
    p_hl      = x_r[63:32] * c[31:0];
    cross_nxt = p_lh[31:0] + p_hl[31:0];
    sum       = ll_r + {cross_r, 32'd0};
    mix       = sum ^ (sum >> 33);
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    home_nxt  = home_r;
    done_nxt  = 1'b0;
    if (start) begin
      x_nxt   = sh ^ (sh >> 33);
      cnt_nxt = 3'd1;
    end else begin
      case (cnt_r)
        3'd1, 3'd3: cnt_nxt = cnt_r + 3'd1;
        3'd2: begin
          x_nxt   = mix;
          cnt_nxt = 3'd3;
        end
        3'd4: begin
          home_nxt = mix[atht_pkg::IDX_W-1:0];
          done_nxt = 1'b1;
          cnt_nxt  = 3'd0;
        end
        default: cnt_nxt = 3'd0;
      endcase
    end
  end

  assign done = done_r;
  assign home = home_r;

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    ll_r    <= ll_nxt;
    cross_r <= cross_nxt;
    home_r  <= home_nxt;
    if (!rst_n) begin
      cnt_r  <= 3'd0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/atht_back.sv =====
`default_nettype none
module atht_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire atht_pkg::cmd_t      head,
  input  wire logic                head_valid,
  output logic                     pop,
  output logic                     clr_busy,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output atht_pkg::out_item_t      out_data
);

  localparam int IW = atht_pkg::IDX_W;
  localparam int CW = atht_pkg::CNT_W;
  localparam int LW = atht_pkg::LIM_W;

  typedef enum logic [14:0] {
    S_CLR      = 15'h0001,
    S_IDLE     = 15'h0002,
    S_HSTART   = 15'h0004,
    S_HWAIT    = 15'h0008,
    S_PR_RD    = 15'h0010,
    S_PR_CHK   = 15'h0020,
    S_CAP      = 15'h0040,
    S_SCAN_RD  = 15'h0080,
    S_SCAN_CHK = 15'h0100,
    S_RB_RD    = 15'h0200,
    S_RB_LD    = 15'h0400,
    S_SUB      = 15'h0800,
    S_ADD      = 15'h1000,
    S_PEAK     = 15'h2000,
    S_OUT      = 15'h4000
  } state_t;

  typedef enum logic [1:0] {
    WALK_REMOVE  = 2'd0,
    WALK_INSERT  = 2'd1,
    WALK_REBUILD = 2'd2
  } walk_t;

  state_t          state_r, state_nxt;
  walk_t           mode_r, mode_nxt;
  atht_pkg::cmd_t  cmd_r, cmd_nxt;
  logic [63:0]     key_r, key_nxt;
  logic            rm_phase_r, rm_phase_nxt;
  logic            rep_r, rep_nxt;
  logic [2:0]      st_r, st_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [IW-1:0]   n_r, n_nxt;
  logic [IW-1:0]   tomb_idx_r, tomb_idx_nxt;
  logic            have_tomb_r, have_tomb_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [CW-1:0]   m_r, m_nxt;
  logic [CW-1:0]   occ_r, occ_nxt;
  logic [CW-1:0]   tomb_r, tomb_nxt;
  logic [47:0]     sub_req_r, sub_req_nxt;
  logic [47:0]     sub_act_r, sub_act_nxt;
  logic [47:0]     rb_req_r, rb_req_nxt;
  logic [47:0]     rb_act_r, rb_act_nxt;
  logic [63:0]     live_req_r, live_req_nxt;
  logic [63:0]     live_act_r, live_act_nxt;
  logic [63:0]     live_cnt_r, live_cnt_nxt;
  logic [63:0]     peak_req_r, peak_req_nxt;
  logic [63:0]     peak_act_r, peak_act_nxt;
  logic [63:0]     peak_cnt_r, peak_cnt_nxt;
  logic [63:0]     total_r, total_nxt;
  logic [63:0]     failed_r, failed_nxt;
  logic [63:0]     realloc_r, realloc_nxt;
  logic            out_valid_r, out_valid_nxt;
  atht_pkg::out_item_t out_data_r, out_data_nxt;

  logic            s_we;
  logic [IW-1:0]   s_waddr, s_raddr;
  atht_pkg::slot_t s_wdata, s_rdata;
  logic            x_we;
  logic [IW-1:0]   x_waddr, x_raddr;
  atht_pkg::entry_t x_wdata, x_rdata;

  logic            h_start, h_done;
  logic [IW-1:0]   h_home;

  logic [LW-1:0]   need_all, need_occ;
  logic            is_empty, is_match, is_tomb, is_last, have_now;
  logic [IW-1:0]   tomb_now;

  atht_ram #(.WIDTH($bits(atht_pkg::slot_t)), .DEPTH(atht_pkg::TABLE_ENTRIES)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // scratch copy of live entries during a rebuild
  atht_ram #(.WIDTH($bits(atht_pkg::entry_t)), .DEPTH(atht_pkg::TABLE_ENTRIES)) u_scr_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (x_waddr),
    .wdata (x_wdata),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  atht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (h_start),
    .key   (key_r),
    .done  (h_done),
    .home  (h_home)
  );

  always_comb begin
    need_all = (LW'(occ_r) + LW'(tomb_r) + LW'(1)) * LW'(10);
    need_occ = (LW'(occ_r) + LW'(1)) * LW'(10);
    is_empty = (s_rdata.mark == atht_pkg::MARK_EMPTY);
    is_tomb  = (s_rdata.mark == atht_pkg::MARK_TOMB);
    is_match = (s_rdata.mark == atht_pkg::MARK_OCC) && (s_rdata.addr == key_r) &&
               (mode_r != WALK_REBUILD);
    is_last  = (n_r == atht_pkg::IDX_MAX);
    have_now = have_tomb_r || is_tomb;
    tomb_now = have_tomb_r ? tomb_idx_r : idx_r;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    rm_phase_nxt  = rm_phase_r;
    rep_nxt       = rep_r;
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    tomb_idx_nxt  = tomb_idx_r;
    have_tomb_nxt = have_tomb_r;
    k_nxt         = k_r;
    m_nxt         = m_r;
    occ_nxt       = occ_r;
    tomb_nxt      = tomb_r;
    sub_req_nxt   = sub_req_r;
    sub_act_nxt   = sub_act_r;
    rb_req_nxt    = rb_req_r;
    rb_act_nxt    = rb_act_r;
    live_req_nxt  = live_req_r;
    live_act_nxt  = live_act_r;
    live_cnt_nxt  = live_cnt_r;
    peak_req_nxt  = peak_req_r;
    peak_act_nxt  = peak_act_r;
    peak_cnt_nxt  = peak_cnt_r;
    total_nxt     = total_r;
    failed_nxt    = failed_r;
    realloc_nxt   = realloc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    h_start       = 1'b0;
    s_we          = 1'b0;
    s_waddr       = idx_r;
    s_wdata       = '0;
    s_raddr       = idx_r;
    x_we          = 1'b0;
    x_waddr       = k_r[IW-1:0];
    x_wdata       = '0;
    x_raddr       = m_r[IW-1:0];

    case (state_r)
      S_CLR: begin
        s_we           = 1'b1;
        s_wdata.mark   = atht_pkg::MARK_EMPTY;
        idx_nxt        = idx_r + 1'b1;
        if (idx_r == atht_pkg::IDX_MAX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (head_valid) begin
          pop          = 1'b1;
          cmd_nxt      = head;
          rm_phase_nxt = 1'b0;
          rep_nxt      = 1'b0;
          case (head.op)
            atht_pkg::OP_IGNORE: begin
              st_nxt    = atht_pkg::ST_NOTFOUND;
              state_nxt = S_OUT;
            end
            atht_pkg::OP_FREE: begin
              key_nxt   = head.addr;
              mode_nxt  = WALK_REMOVE;
              state_nxt = S_HSTART;
            end
            atht_pkg::OP_ALLOC: begin
              state_nxt = S_CAP;
            end
            atht_pkg::OP_REALLOC: begin
              if (head.old_addr != 64'd0) begin
                key_nxt      = head.old_addr;
                mode_nxt     = WALK_REMOVE;
                rm_phase_nxt = 1'b1;
                state_nxt    = S_HSTART;
              end else begin
                state_nxt = S_CAP;
              end
            end
            default: begin
              failed_nxt = failed_r + 64'd1;
              st_nxt     = atht_pkg::ST_FAILED;
              state_nxt  = S_OUT;
            end
          endcase
        end
      end

      S_CAP: begin
        if (need_all >= atht_pkg::TBL_LIM) begin
          if (need_occ >= atht_pkg::TBL_LIM) begin
            failed_nxt = failed_r + 64'd1;
            st_nxt     = atht_pkg::ST_FAILED;
            state_nxt  = S_OUT;
          end else begin
            idx_nxt   = '0;
            k_nxt     = '0;
            state_nxt = S_SCAN_RD;
          end
        end else begin
          key_nxt   = cmd_r.addr;
          mode_nxt  = WALK_INSERT;
          state_nxt = S_HSTART;
        end
      end

      S_HSTART: begin
        h_start   = 1'b1;
        state_nxt = S_HWAIT;
      end

      S_HWAIT: begin
        if (h_done) begin
          idx_nxt       = h_home;
          n_nxt         = '0;
          have_tomb_nxt = 1'b0;
          state_nxt     = S_PR_RD;
        end
      end

      S_PR_RD: begin
        state_nxt = S_PR_CHK;
      end

      S_PR_CHK: begin
        if (is_match) begin
          sub_req_nxt = s_rdata.req;
          sub_act_nxt = s_rdata.act;
          s_we        = 1'b1;
          s_wdata     = '{addr: key_r, req: cmd_r.req, act: cmd_r.act,
                          mark: atht_pkg::MARK_OCC};
          if (mode_r == WALK_REMOVE) begin
            s_wdata.mark = atht_pkg::MARK_TOMB;
            occ_nxt      = (occ_r != '0) ? occ_r - CW'(1) : occ_r;
            tomb_nxt     = tomb_r + CW'(1);
          end else begin
            rep_nxt = 1'b1;
            st_nxt  = atht_pkg::ST_REPLACED;
          end
          state_nxt = S_SUB;
        end else if (is_empty || is_last) begin
          case (mode_r)
            WALK_REMOVE: begin
              if (rm_phase_r) begin
                rm_phase_nxt = 1'b0;
                state_nxt    = S_CAP;
              end else begin
                st_nxt    = atht_pkg::ST_NOTFOUND;
                state_nxt = S_OUT;
              end
            end
            WALK_INSERT: begin
              if (is_empty || have_now) begin
                s_we     = 1'b1;
                s_waddr  = have_now ? tomb_now : idx_r;
                s_wdata  = '{addr: key_r, req: cmd_r.req, act: cmd_r.act,
                             mark: atht_pkg::MARK_OCC};
                occ_nxt  = occ_r + CW'(1);
                if (have_now && (tomb_r != '0)) begin
                  tomb_nxt = tomb_r - CW'(1);
                end
                st_nxt    = atht_pkg::ST_NEW;
                state_nxt = S_ADD;
              end else begin
                failed_nxt = failed_r + 64'd1;
                st_nxt     = atht_pkg::ST_FAILED;
                state_nxt  = S_OUT;
              end
            end
            default: begin
              s_we    = 1'b1;
              s_wdata = '{addr: key_r, req: rb_req_r, act: rb_act_r,
                          mark: atht_pkg::MARK_OCC};
              occ_nxt = occ_r + CW'(1);
              m_nxt   = m_r + CW'(1);
              if (m_r + CW'(1) == k_r) begin
                key_nxt   = cmd_r.addr;
                mode_nxt  = WALK_INSERT;
                state_nxt = S_HSTART;
              end else begin
                state_nxt = S_RB_RD;
              end
            end
          endcase
        end else begin
          have_tomb_nxt = have_now;
          tomb_idx_nxt  = tomb_now;
          idx_nxt       = idx_r + 1'b1;
          n_nxt         = n_r + 1'b1;
          state_nxt     = S_PR_RD;
        end
      end

      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        if (s_rdata.mark == atht_pkg::MARK_OCC) begin
          x_we    = 1'b1;
          x_wdata = '{addr: s_rdata.addr, req: s_rdata.req, act: s_rdata.act};
          k_nxt   = k_r + CW'(1);
        end
        s_we         = 1'b1;
        s_wdata.mark = atht_pkg::MARK_EMPTY;
        idx_nxt      = idx_r + 1'b1;
        if (idx_r == atht_pkg::IDX_MAX) begin
          occ_nxt  = '0;
          tomb_nxt = '0;
          m_nxt    = '0;
          if (k_nxt == '0) begin
            key_nxt   = cmd_r.addr;
            mode_nxt  = WALK_INSERT;
            state_nxt = S_HSTART;
          end else begin
            state_nxt = S_RB_RD;
          end
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end

      S_RB_RD: begin
        state_nxt = S_RB_LD;
      end

      S_RB_LD: begin
        key_nxt    = x_rdata.addr;
        rb_req_nxt = x_rdata.req;
        rb_act_nxt = x_rdata.act;
        mode_nxt   = WALK_REBUILD;
        state_nxt  = S_HSTART;
      end

      S_SUB: begin
        live_req_nxt = (live_req_r >= 64'(sub_req_r)) ? live_req_r - 64'(sub_req_r) : 64'd0;
        live_act_nxt = (live_act_r >= 64'(sub_act_r)) ? live_act_r - 64'(sub_act_r) : 64'd0;
        live_cnt_nxt = (live_cnt_r != 64'd0) ? live_cnt_r - 64'd1 : live_cnt_r;
        if (rep_r) begin
          state_nxt = S_ADD;
        end else if (rm_phase_r) begin
          rm_phase_nxt = 1'b0;
          state_nxt    = S_CAP;
        end else begin
          st_nxt    = atht_pkg::ST_REMOVED;
          state_nxt = S_OUT;
        end
      end

      S_ADD: begin
        live_req_nxt = live_req_r + 64'(cmd_r.req);
        live_act_nxt = live_act_r + 64'(cmd_r.act);
        live_cnt_nxt = live_cnt_r + 64'd1;
        total_nxt    = total_r + 64'd1;
        if ((cmd_r.op == atht_pkg::OP_REALLOC) && (cmd_r.old_addr != 64'd0)) begin
          realloc_nxt = realloc_r + 64'd1;
        end
        state_nxt = S_PEAK;
      end

      S_PEAK: begin
        peak_req_nxt = (live_req_r > peak_req_r) ? live_req_r : peak_req_r;
        peak_act_nxt = (live_act_r > peak_act_r) ? live_act_r : peak_act_r;
        peak_cnt_nxt = (live_cnt_r > peak_cnt_r) ? live_cnt_r : peak_cnt_r;
        state_nxt    = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                     = 1'b1;
          out_data_nxt.status               = st_r;
          out_data_nxt.live_requested_bytes = live_req_r;
          out_data_nxt.live_actual_bytes    = live_act_r;
          out_data_nxt.live_count           = live_cnt_r;
          out_data_nxt.peak_requested_bytes = peak_req_r;
          out_data_nxt.peak_actual_bytes    = peak_act_r;
          out_data_nxt.peak_count           = peak_cnt_r;
          out_data_nxt.total_count          = total_r;
          out_data_nxt.failed_count         = failed_r;
          out_data_nxt.realloc_count        = realloc_r;
          out_data_nxt.slack_bytes          = (live_act_r > live_req_r) ?
                                              live_act_r - live_req_r : 64'd0;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign clr_busy  = (state_r == S_CLR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    st_r       <= st_nxt;
    n_r        <= n_nxt;
    tomb_idx_r <= tomb_idx_nxt;
    sub_req_r  <= sub_req_nxt;
    sub_act_r  <= sub_act_nxt;
    rb_req_r   <= rb_req_nxt;
    rb_act_r   <= rb_act_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_CLR;
      mode_r      <= WALK_REMOVE;
      rm_phase_r  <= 1'b0;
      rep_r       <= 1'b0;
      idx_r       <= '0;
      have_tomb_r <= 1'b0;
      k_r         <= '0;
      m_r         <= '0;
      occ_r       <= '0;
      tomb_r      <= '0;
      live_req_r  <= 64'd0;
      live_act_r  <= 64'd0;
      live_cnt_r  <= 64'd0;
      peak_req_r  <= 64'd0;
      peak_act_r  <= 64'd0;
      peak_cnt_r  <= 64'd0;
      total_r     <= 64'd0;
      failed_r    <= 64'd0;
      realloc_r   <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      rm_phase_r  <= rm_phase_nxt;
      rep_r       <= rep_nxt;
      idx_r       <= idx_nxt;
      have_tomb_r <= have_tomb_nxt;
      k_r         <= k_nxt;
      m_r         <= m_nxt;
      occ_r       <= occ_nxt;
      tomb_r      <= tomb_nxt;
      live_req_r  <= live_req_nxt;
      live_act_r  <= live_act_nxt;
      live_cnt_r  <= live_cnt_nxt;
      peak_req_r  <= peak_req_nxt;
      peak_act_r  <= peak_act_nxt;
      peak_cnt_r  <= peak_cnt_nxt;
      total_r     <= total_nxt;
      failed_r    <= failed_nxt;
      realloc_r   <= realloc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/allocation_tracking_hash_table.sv =====
// Failure reports and zero-address requests go straight to the result; a free or an alloc
//   hashes its key, then probes from the home slot until a match, an empty slot or a full lap.
// The back end takes one request at a time; a realloc with old_addr != 0 walks the table twice.
// A rebuild sweeps all TABLE_ENTRIES slots, copying live entries to scratch and emptying each slot,
//   then rehashes and reinserts each live entry.
// Reset (rst_n low, synchronous) clears counters, then a clearing pass empties all TABLE_ENTRIES slots.
`default_nettype none
module allocation_tracking_hash_table (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire atht_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output atht_pkg::out_item_t      out_data
);

  // front: 2-entry command queue with request classification
  atht_pkg::cmd_t head;
  logic           head_valid;
  logic           pop;
  logic           clr_busy;

  atht_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .clr_busy   (clr_busy),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // back: hash, linear probe, rebuild sequencer, statistics and result register
  atht_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .clr_busy   (clr_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/core/atht_checker.sv =====
`default_nettype none
module atht_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire atht_pkg::out_item_t out_data
);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= atht_pkg::ST_FAILED)
    else $error("bad status code");

  a_peak_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.peak_count >= out_data.live_count)
    else $error("peak count below live count");

  a_slack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.slack_bytes ==
      ((out_data.live_actual_bytes > out_data.live_requested_bytes) ?
       out_data.live_actual_bytes - out_data.live_requested_bytes : 64'd0))
    else $error("slack mismatch");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result out of reset");

endmodule

bind allocation_tracking_hash_table atht_checker u_chk (.*);
`default_nettype wire
